[rtl/icw_pkg.sv]
// Shared types, widths and constants of the iterated cubic waveshaper.
package icw_pkg;

   // Defaults of the top-level parameters.
   localparam int DEF_MAX_DEPTH   = 32;
   localparam int DEF_SAMPLE_BITS = 16;

   // Fixed-point formats: s is Q8.24 in 32 bits, coefficients are Q6.16.
   localparam int FIX_W   = 32;
   localparam int FRAC_S  = 24;
   localparam int FRAC_C  = 16;
   localparam int COEF_W  = 22;
   localparam int PROD_W  = 2 * FIX_W;
   localparam int CPROD_W = COEF_W + FIX_W;
   localparam int SUM_W   = CPROD_W + 2;

   // Stereo lanes.
   localparam int NUM_LANES  = 2;
   localparam int LANE_LEFT  = 0;
   localparam int LANE_RIGHT = 1;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int AMOUNT_W    = 16;
   localparam int DEPTH_REG_W = 6;
   localparam logic [CSR_INDEX_W-1:0] CSR_EFFECT_AMOUNT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ITERATION_DEPTH = 2'd1;
   localparam int AMOUNT_RESET = 128;
   localparam int DEPTH_RESET  = 1;

   // Linear coefficient E = 9 * amount / 65534, rounded half up.
   localparam int AMOUNT_GAIN = 9;
   localparam int AMOUNT_DIV  = 65534;
   localparam int AMOUNT_RND  = 32767;
   localparam int ONE_Q16     = 65536;

   typedef logic signed [FIX_W-1:0] fix_type;

   localparam fix_type FIX_MAX = 32'sh7FFF_FFFF;
   localparam fix_type FIX_MIN = 32'sh8000_0000;
   localparam fix_type ONE_Q24 = 32'sh0100_0000;

   typedef struct packed {
      logic signed [COEF_W-1:0] a;
      logic signed [COEF_W-1:0] b;
      logic signed [COEF_W-1:0] e;
   } coef_type;

   typedef struct packed {
      logic valid;
      logic block_end;
   } ctl_type;

endpackage

[rtl/icw_coef.sv]
// Configuration registers and derivation of the cubic map coefficients.
module icw_coef #(
   parameter int MAX_DEPTH = icw_pkg::DEF_MAX_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [icw_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [icw_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output icw_pkg::coef_type                 coef,
   output logic [$clog2(MAX_DEPTH+1)-1:0]    depth_eff
);
   import icw_pkg::*;

   localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
   localparam logic signed [COEF_W-1:0] THREE_Q16 = COEF_W'(3 * ONE_Q16);
   localparam logic signed [COEF_W-1:0] TWO_Q16   = COEF_W'(2 * ONE_Q16);

   coef_type                 coef_ff;
   logic [DEPTH_REG_W-1:0]   depth_ff;
   logic [DEPTH_REG_W:0]     depth_wide;

   // E = m + floor((2m + 32767) / 65534) with m = 9 * amount. The quotient is
   // taken as the top bits, then corrected once since the remainder stays
   // below twice the divisor.
   function automatic coef_type derive(input logic [AMOUNT_W-1:0] amount);
      logic [19:0] m;
      logic [20:0] v;
      logic [4:0]  q0;
      logic [16:0] r;
      logic [19:0] e;
      coef_type    c;
      m   = 20'(amount) * 20'(AMOUNT_GAIN);
      v   = {m, 1'b0} + 21'(AMOUNT_RND);
      q0  = v[20:16];
      r   = 17'(v[15:0]) + 17'({q0, 1'b0});
      e   = m + 20'(q0) + ((r >= 17'(AMOUNT_DIV)) ? 20'd1 : 20'd0);
      c.e = $signed({2'b00, e});
      c.b = THREE_Q16 - (c.e + (c.e <<< 1));
      c.a = (c.e <<< 1) - TWO_Q16;
      return c;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff  <= derive(AMOUNT_W'(AMOUNT_RESET));
         depth_ff <= DEPTH_REG_W'(DEPTH_RESET);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_EFFECT_AMOUNT: begin
               coef_ff <= derive(csr_wdata[AMOUNT_W-1:0]);
            end
            CSR_ITERATION_DEPTH: begin
               depth_ff <= csr_wdata[DEPTH_REG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign depth_wide = {1'b0, depth_ff};
   assign depth_eff  = (depth_wide > (DEPTH_REG_W+1)'(MAX_DEPTH)) ?
                       DEPTH_W'(MAX_DEPTH) : DEPTH_W'(depth_wide);
   assign coef       = coef_ff;
   assign csr_ready  = 1'b1;

   a_coef_sum_is_one: assert property (@(posedge clock) disable iff (reset)
      (coef_ff.a + coef_ff.b + coef_ff.e) == COEF_W'(ONE_Q16))
      else $error("cubic coefficients do not sum to one");

   a_linear_term_nonneg: assert property (@(posedge clock) disable iff (reset)
      csr_valid && (csr_index == CSR_EFFECT_AMOUNT) |=> !coef_ff.e[COEF_W-1])
      else $error("linear coefficient went negative");

endmodule

[rtl/icw_iter.sv]
// One application of the cubic map to both lanes, as six pipeline stages.
module icw_iter (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                active,
   input  icw_pkg::coef_type   coef,
   input  icw_pkg::ctl_type    in_ctl,
   input  icw_pkg::fix_type    in_s  [icw_pkg::NUM_LANES],
   output icw_pkg::ctl_type    out_ctl,
   output icw_pkg::fix_type    out_s [icw_pkg::NUM_LANES]
);
   import icw_pkg::*;

   localparam int STAGES = 6;
   localparam int Q_W    = PROD_W - FRAC_S;
   localparam logic signed [Q_W-1:0] Q_HI = Q_W'(FIX_MAX);
   localparam logic signed [Q_W-1:0] Q_LO = Q_W'(FIX_MIN);

   ctl_type                    stage_ctl_ff [STAGES];
   logic signed [PROD_W-1:0]   sq_ff     [NUM_LANES];
   logic signed [PROD_W-1:0]   cu_ff     [NUM_LANES];
   logic signed [CPROD_W-1:0]  pb_ff     [NUM_LANES];
   logic signed [CPROD_W-1:0]  pe_ff     [NUM_LANES];
   logic signed [CPROD_W-1:0]  pa_ff     [NUM_LANES];
   logic signed [SUM_W-1:0]    part_d_ff [NUM_LANES];
   logic signed [SUM_W-1:0]    part_e_ff [NUM_LANES];
   fix_type                    ss_ff     [NUM_LANES];
   fix_type                    cube_ff   [NUM_LANES];
   fix_type                    s_a_ff    [NUM_LANES];
   fix_type                    s_b_ff    [NUM_LANES];
   fix_type                    s_c_ff    [NUM_LANES];
   fix_type                    s_d_ff    [NUM_LANES];
   fix_type                    s_e_ff    [NUM_LANES];
   fix_type                    s_out_ff  [NUM_LANES];
   fix_type                    ss_in     [NUM_LANES];
   fix_type                    cube_in   [NUM_LANES];
   logic signed [SUM_W-1:0]    part_in   [NUM_LANES];
   fix_type                    s_next_in [NUM_LANES];

   // Round half up from Q.48 to Q8.24 and saturate to 32 bits.
   function automatic fix_type round_sat_q24(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] t;
      logic signed [Q_W-1:0]    q;
      fix_type                  r;
      t = v + PROD_W'(1 << (FRAC_S - 1));
      q = Q_W'(t >>> FRAC_S);
      if (q > Q_HI) begin
         r = FIX_MAX;
      end else if (q < Q_LO) begin
         r = FIX_MIN;
      end else begin
         r = q[FIX_W-1:0];
      end
      return r;
   endfunction

   // Round half up from Q.40 to Q8.24 and saturate to 32 bits.
   function automatic fix_type round_sat_q16(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0]        t;
      logic signed [SUM_W-FRAC_C-1:0] q;
      fix_type                        r;
      t = v + SUM_W'(1 << (FRAC_C - 1));
      q = (SUM_W-FRAC_C)'(t >>> FRAC_C);
      if (q > (SUM_W-FRAC_C)'(FIX_MAX)) begin
         r = FIX_MAX;
      end else if (q < (SUM_W-FRAC_C)'(FIX_MIN)) begin
         r = FIX_MIN;
      end else begin
         r = q[FIX_W-1:0];
      end
      return r;
   endfunction

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         ss_in[l]   = round_sat_q24(sq_ff[l]);
         cube_in[l] = round_sat_q24(cu_ff[l]);
         part_in[l] = SUM_W'(pb_ff[l]) + SUM_W'(pe_ff[l]);
         // An iteration beyond the configured depth passes s through.
         s_next_in[l] = active ? round_sat_q16(SUM_W'(pa_ff[l]) + part_e_ff[l])
                               : s_e_ff[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STAGES; k++) begin
            stage_ctl_ff[k] <= '0;
         end
      end else if (en) begin
         stage_ctl_ff[0] <= in_ctl;
         for (int k = 1; k < STAGES; k++) begin
            stage_ctl_ff[k] <= stage_ctl_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            sq_ff[l]     <= PROD_W'(in_s[l]) * PROD_W'(in_s[l]);
            s_a_ff[l]    <= in_s[l];
            ss_ff[l]     <= ss_in[l];
            s_b_ff[l]    <= s_a_ff[l];
            cu_ff[l]     <= PROD_W'(ss_ff[l]) * PROD_W'(s_b_ff[l]);
            pb_ff[l]     <= CPROD_W'(coef.b) * CPROD_W'(ss_ff[l]);
            pe_ff[l]     <= CPROD_W'(coef.e) * CPROD_W'(s_b_ff[l]);
            s_c_ff[l]    <= s_b_ff[l];
            cube_ff[l]   <= cube_in[l];
            part_d_ff[l] <= part_in[l];
            s_d_ff[l]    <= s_c_ff[l];
            pa_ff[l]     <= CPROD_W'(coef.a) * CPROD_W'(cube_ff[l]);
            part_e_ff[l] <= part_d_ff[l];
            s_e_ff[l]    <= s_d_ff[l];
            s_out_ff[l]  <= s_next_in[l];
         end
      end
   end

   assign out_ctl = stage_ctl_ff[STAGES-1];
   assign out_s   = s_out_ff;

endmodule

[rtl/icw_out.sv]
// Mapping back to sample range with clamping, output register and skid stage.
module icw_out #(
   parameter int SAMPLE_BITS = icw_pkg::DEF_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  icw_pkg::ctl_type              in_ctl,
   input  icw_pkg::fix_type              in_s [icw_pkg::NUM_LANES],
   output logic                          pipe_en,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS:0]   rsp_left_result,
   output logic signed [SAMPLE_BITS:0]   rsp_right_result,
   output logic                          rsp_block_end_out
);
   import icw_pkg::*;

   localparam int OUT_SH = FRAC_S - SAMPLE_BITS;
   localparam logic [FIX_W-1:0]       OUT_ROUND = FIX_W'((1 << OUT_SH) >> 1);
   localparam logic [SAMPLE_BITS:0]   RES_HALF  = (SAMPLE_BITS+1)'(1 << (SAMPLE_BITS - 1));
   localparam logic signed [SAMPLE_BITS:0] RES_HI = RES_HALF;
   localparam logic signed [SAMPLE_BITS:0] RES_LO = -RES_HI;

   logic signed [SAMPLE_BITS:0]  res_in      [NUM_LANES];
   logic signed [SAMPLE_BITS:0]  out_res_ff  [NUM_LANES];
   logic signed [SAMPLE_BITS:0]  skid_res_ff [NUM_LANES];
   logic                         out_valid_ff;
   logic                         out_end_ff;
   logic                         skid_valid_ff;
   logic                         skid_end_ff;
   logic                         move_skid;
   logic                         load_out;
   logic                         load_skid;

   always_comb begin
      logic [FIX_W-1:0]       t;
      logic [SAMPLE_BITS:0]   q;
      for (int l = 0; l < NUM_LANES; l++) begin
         t = $unsigned(in_s[l]) + OUT_ROUND;
         q = (SAMPLE_BITS+1)'(t >> OUT_SH);
         if (in_s[l][FIX_W-1]) begin
            res_in[l] = RES_LO;
         end else if (in_s[l] > ONE_Q24) begin
            res_in[l] = RES_HI;
         end else begin
            res_in[l] = $signed(q - RES_HALF);
         end
      end
   end

   // The pipeline only stalls once the skid stage is occupied, so the one
   // request that arrives behind a refused result always has a place.
   assign pipe_en   = !skid_valid_ff;
   assign move_skid = skid_valid_ff && rsp_ready;
   assign load_out  = !skid_valid_ff && in_ctl.valid && (!out_valid_ff || rsp_ready);
   assign load_skid = !skid_valid_ff && in_ctl.valid && out_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_ready) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (in_ctl.valid) begin
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move_skid) begin
         out_res_ff <= skid_res_ff;
         out_end_ff <= skid_end_ff;
      end else if (load_out) begin
         out_res_ff <= res_in;
         out_end_ff <= in_ctl.block_end;
      end
      if (load_skid) begin
         skid_res_ff <= res_in;
         skid_end_ff <= in_ctl.block_end;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_left_result   = out_res_ff[LANE_LEFT];
   assign rsp_right_result  = out_res_ff[LANE_RIGHT];
   assign rsp_block_end_out = out_end_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a result while the output register is empty");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready && !skid_valid_ff && in_ctl.valid
      |=> skid_valid_ff && out_valid_ff)
      else $error("arriving result was not captured during a stall");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_ready |=> skid_valid_ff && $stable(skid_end_ff))
      else $error("skid stage lost its result while the output was stalled");

endmodule

[rtl/iterated_cubic_waveshaper_core.sv]
// Top level of the iterated cubic waveshaper.
// Stereo waveshaper: each request carries a left and right sample that are
// mapped to the unit interval and passed through the cubic map
// s -> A*s^3 + B*s^2 + E*s as many times as iteration_depth says (clamped to
// MAX_DEPTH), then mapped back and clamped to plus or minus half scale. One
// request is accepted every cycle while the skid stage is empty. Whatever the
// depth, a request reaches rsp_valid through one entry register, six
// stages for each of the MAX_DEPTH unrolled iterations (square, round, three
// parallel products, round and add, cubic product, sum and round), and the
// output register. Iterations past the configured depth pass the sample on
// unchanged. A skid stage behind the output register keeps the pipeline
// moving while one result waits to be taken. csr_ready is always high;
// a coefficient write takes effect at the next clock edge, and registers are
// to be written only while no request is in flight.
module iterated_cubic_waveshaper_core #(
   parameter int MAX_DEPTH   = icw_pkg::DEF_MAX_DEPTH,
   parameter int SAMPLE_BITS = icw_pkg::DEF_SAMPLE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [SAMPLE_BITS-1:0]     req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0]     req_right_sample,
   input  logic                              req_block_end,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [SAMPLE_BITS:0]       rsp_left_result,
   output logic signed [SAMPLE_BITS:0]       rsp_right_result,
   output logic                              rsp_block_end_out,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [icw_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [icw_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import icw_pkg::*;

   localparam int DEPTH_W  = $clog2(MAX_DEPTH + 1);
   localparam int ENTRY_SH = FRAC_S - SAMPLE_BITS;

   coef_type              coef;
   logic [DEPTH_W-1:0]    depth_eff;
   logic [MAX_DEPTH-1:0]  iter_active;
   logic                  pipe_en;
   ctl_type               entry_ctl_ff;
   fix_type               entry_s_ff [NUM_LANES];
   fix_type               req_s      [NUM_LANES];
   ctl_type               chain_ctl  [MAX_DEPTH+1];
   fix_type               chain_s    [MAX_DEPTH+1][NUM_LANES];

   // Offset binary sample placed in the fraction of Q8.24.
   function automatic fix_type to_unit(input logic signed [SAMPLE_BITS-1:0] x);
      return fix_type'({{(FIX_W-SAMPLE_BITS){1'b0}}, ~x[SAMPLE_BITS-1],
                        x[SAMPLE_BITS-2:0]} << ENTRY_SH);
   endfunction

   icw_coef #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_coef (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef),
      .depth_eff (depth_eff)
   );

   assign req_ready = pipe_en;

   always_comb begin
      req_s[LANE_LEFT]  = to_unit(req_left_sample);
      req_s[LANE_RIGHT] = to_unit(req_right_sample);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ctl_ff <= '0;
      end else if (pipe_en) begin
         entry_ctl_ff.valid     <= req_valid;
         entry_ctl_ff.block_end <= req_block_end;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         entry_s_ff <= req_s;
      end
   end

   assign chain_ctl[0] = entry_ctl_ff;
   assign chain_s[0]   = entry_s_ff;

   for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_iter
      assign iter_active[i] = depth_eff > DEPTH_W'(i);

      icw_iter u_iter (
         .clock   (clock),
         .reset   (reset),
         .en      (pipe_en),
         .active  (iter_active[i]),
         .coef    (coef),
         .in_ctl  (chain_ctl[i]),
         .in_s    (chain_s[i]),
         .out_ctl (chain_ctl[i+1]),
         .out_s   (chain_s[i+1])
      );
   end

   icw_out #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_out (
      .clock             (clock),
      .reset             (reset),
      .in_ctl            (chain_ctl[MAX_DEPTH]),
      .in_s              (chain_s[MAX_DEPTH]),
      .pipe_en           (pipe_en),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_left_result   (rsp_left_result),
      .rsp_right_result  (rsp_right_result),
      .rsp_block_end_out (rsp_block_end_out)
   );

endmodule

[dv/iterated_cubic_waveshaper_core_tb.sv]
// Self-checking testbench for the iterated cubic waveshaper core.
module iterated_cubic_waveshaper_core_tb;
   import icw_pkg::*;

   localparam int SAMPLE_BITS = DEF_SAMPLE_BITS;
   localparam int MAX_DEPTH   = DEF_MAX_DEPTH;
   localparam int PIPE_CYCLES = 6 * MAX_DEPTH + 2;
   localparam int STALL_LIMIT = 4000;
   localparam int NUM_PHASES  = 12;
   localparam int PHASE_ITEMS = 125;

   // Indexes that the block does not decode.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [SAMPLE_BITS:0]   shaped_type;

   typedef struct packed {
      shaped_type left;
      shaped_type right;
      logic       blk;
   } shaped_pair_type;

   typedef struct packed {
      bit                     is_csr;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  wdata;
      sample_type             left;
      sample_type             right;
      logic                   blk;
      bit                     typed;
      shaped_pair_type        want;
   } step_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   sample_type             req_left_sample;
   sample_type             req_right_sample;
   logic                   req_block_end;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b1;
   shaped_type             rsp_left_result;
   shaped_type             rsp_right_result;
   logic                   rsp_block_end_out;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Predictor copy of the registers and derived Q6.16 coefficients.
   logic [DEPTH_REG_W-1:0] depth_reg;
   longint                 coef_e;
   longint                 coef_b;
   longint                 coef_a;

   shaped_pair_type shaped_q[$];
   int              error_count;
   int              pairs_sent;
   int              results_checked;
   int              csr_writes;
   int              send_idle_pct;
   int              recv_stall_pct;
   int              quiet_cycles;

   iterated_cubic_waveshaper_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_left_sample   (req_left_sample),
      .req_right_sample  (req_right_sample),
      .req_block_end     (req_block_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_left_result   (rsp_left_result),
      .rsp_right_result  (rsp_right_result),
      .rsp_block_end_out (rsp_block_end_out),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Round half up of v / 2^k; the arithmetic shift floors negative values.
   function automatic longint round_half_up(longint v, int k);
      return (v + (longint'(1) << (k - 1))) >>> k;
   endfunction

   function automatic longint clip_fix(longint v);
      if (v > longint'(FIX_MAX)) return longint'(FIX_MAX);
      if (v < longint'(FIX_MIN)) return longint'(FIX_MIN);
      return v;
   endfunction

   function automatic void load_amount(logic [AMOUNT_W-1:0] amount);
      coef_e = (longint'(amount) * AMOUNT_GAIN * ONE_Q16 + AMOUNT_RND) / AMOUNT_DIV;
      coef_b = 3 * ONE_Q16 - 3 * coef_e;
      coef_a = ONE_Q16 - coef_e - coef_b;
   endfunction

   function automatic shaped_type shape_sample(sample_type x);
      longint half;
      longint s;
      longint sq;
      longint cube;
      longint sum;
      int     passes;
      half   = longint'(1) << (SAMPLE_BITS - 1);
      s      = (longint'(x) + half) <<< (FRAC_S - SAMPLE_BITS);
      passes = (depth_reg > MAX_DEPTH) ? MAX_DEPTH : int'(depth_reg);
      for (int i = 0; i < passes; i++) begin
         sq   = clip_fix(round_half_up(s * s, FRAC_S));
         cube = clip_fix(round_half_up(sq * s, FRAC_S));
         sum  = coef_a * cube + coef_b * sq + coef_e * s;
         s    = clip_fix(round_half_up(sum, FRAC_C));
      end
      if (s < 0) return shaped_type'(-half);
      if (s > longint'(ONE_Q24)) return shaped_type'(half);
      return shaped_type'(round_half_up(s, FRAC_S - SAMPLE_BITS) - half);
   endfunction

   function automatic shaped_pair_type predict_pair(sample_type l, sample_type r, logic b);
      shaped_pair_type p;
      p.left  = shape_sample(l);
      p.right = shape_sample(r);
      p.blk   = b;
      return p;
   endfunction

   function automatic step_type csr_row(logic [CSR_INDEX_W-1:0] idx,
                                        logic [CSR_DATA_W-1:0] data);
      step_type st;
      st        = '0;
      st.is_csr = 1'b1;
      st.index  = idx;
      st.wdata  = data;
      return st;
   endfunction

   function automatic step_type pair_row(sample_type l, sample_type r, logic b);
      step_type st;
      st       = '0;
      st.left  = l;
      st.right = r;
      st.blk   = b;
      return st;
   endfunction

   function automatic step_type known_row(sample_type l, sample_type r, logic b,
                                          shaped_type wl, shaped_type wr);
      step_type st;
      st       = pair_row(l, r, b);
      st.typed = 1'b1;
      st.want  = '{left: wl, right: wr, blk: b};
      return st;
   endfunction

   function automatic sample_type pick_sample();
      logic [SAMPLE_BITS-1:0] v;
      v = SAMPLE_BITS'($urandom);
      case ($urandom_range(7))
         0: v = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         1: v = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         2: v = {{(SAMPLE_BITS-8){v[7]}}, v[7:0]};
         default: ;
      endcase
      return sample_type'(v);
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Stops new requests and waits until every outstanding result has come back.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (shaped_q.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      drain();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_EFFECT_AMOUNT) load_amount(data[AMOUNT_W-1:0]);
      else if (idx == CSR_ITERATION_DEPTH) depth_reg = data[DEPTH_REG_W-1:0];
      csr_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_pair(sample_type l, sample_type r, logic b, bit typed,
                            shaped_pair_type want);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid        = 1'b1;
      req_left_sample  = l;
      req_right_sample = r;
      req_block_end    = b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      shaped_q.push_back(typed ? want : predict_pair(l, r, b));
      pairs_sent++;
   endtask

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      shaped_pair_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (shaped_q.size() == 0) begin
            report_mismatch("unexpected result, left", rsp_left_result, 0);
         end else begin
            want = shaped_q.pop_front();
            if (rsp_left_result !== want.left)
               report_mismatch("left_result", rsp_left_result, want.left);
            if (rsp_right_result !== want.right)
               report_mismatch("right_result", rsp_right_result, want.right);
            if (rsp_block_end_out !== want.blk)
               report_mismatch("block_end_out", rsp_block_end_out, want.blk);
            results_checked++;
         end
      end
   end

   // Ends the run if no channel moves anything for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("iterated_cubic_waveshaper_core test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      step_type        plan [27];
      shaped_pair_type none;
      logic [15:0]     amount;
      logic [15:0]     depth;
      none             = '0;
      error_count      = 0;
      pairs_sent       = 0;
      results_checked  = 0;
      csr_writes       = 0;
      quiet_cycles     = 0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_left_sample  = '0;
      req_right_sample = '0;
      req_block_end    = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      load_amount(AMOUNT_W'(AMOUNT_RESET));
      depth_reg = DEPTH_REG_W'(DEPTH_RESET);

      plan = '{
         // Zero stays at zero through any number of passes.
         known_row(-16'sd32768, -16'sd32768, 1'b1, -17'sd32768, -17'sd32768),
         pair_row(16'sd32767, -16'sd1, 1'b0),
         pair_row(16'sd0, 16'sd1, 1'b1),
         pair_row(16'sd23130, -16'sd23131, 1'b0),
         // With no passes the sample comes back unchanged.
         csr_row(CSR_ITERATION_DEPTH, 16'd0),
         known_row(16'sd32767, -16'sd32768, 1'b1, 17'sd32767, -17'sd32768),
         known_row(16'sd21845, -16'sd21846, 1'b0, 17'sd21845, -17'sd21846),
         csr_row(CSR_EFFECT_AMOUNT, 16'd0),
         csr_row(CSR_ITERATION_DEPTH, 16'd1),
         pair_row(16'sd32767, -16'sd32768, 1'b1),
         pair_row(-16'sd16384, 16'sd16384, 1'b0),
         // Strongest legal amount over the deepest chain drives s into saturation.
         csr_row(CSR_EFFECT_AMOUNT, 16'd65534),
         csr_row(CSR_ITERATION_DEPTH, 16'd32),
         pair_row(16'sd32767, -16'sd32767, 1'b0),
         pair_row(16'sd100, -16'sd100, 1'b1),
         csr_row(CSR_EFFECT_AMOUNT, 16'hFFFF),
         pair_row(16'sd32767, 16'sd0, 1'b0),
         // A depth past the maximum is held at the maximum.
         csr_row(CSR_ITERATION_DEPTH, 16'hFFFF),
         pair_row(-16'sd1, 16'sd1, 1'b1),
         csr_row(CSR_SPARE_2, 16'h0000),
         csr_row(CSR_SPARE_3, 16'hFFFF),
         pair_row(16'sd12345, -16'sd12345, 1'b0),
         csr_row(CSR_EFFECT_AMOUNT, 16'd7282),
         // Only the low six bits of the depth write are kept.
         csr_row(CSR_ITERATION_DEPTH, 16'hFFC5),
         pair_row(16'sd32767, -16'sd32768, 1'b1),
         pair_row(16'sd1000, -16'sd20000, 1'b0),
         known_row(-16'sd32768, -16'sd32768, 1'b0, -17'sd32768, -17'sd32768)
      };

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_csr) csr_write(plan[i].index, plan[i].wdata);
         else send_pair(plan[i].left, plan[i].right, plan[i].blk, plan[i].typed,
                        plan[i].want);
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case ($urandom_range(5))
            0: amount = 16'd0;
            1: amount = 16'd65534;
            2: amount = 16'hFFFF;
            3: amount = 16'($urandom_range(6000, 10000));
            4: amount = 16'($urandom_range(2000));
            default: amount = 16'($urandom);
         endcase
         case ($urandom_range(4))
            0: depth = 16'd0;
            1: depth = 16'd32;
            2: depth = 16'($urandom_range(33, 63));
            3: depth = 16'($urandom_range(1, 4));
            default: depth = 16'($urandom);
         endcase
         csr_write(CSR_EFFECT_AMOUNT, amount);
         csr_write(CSR_ITERATION_DEPTH, depth);
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase % 3 == 0 && n == PHASE_ITEMS / 2) drain();
            send_pair(pick_sample(), pick_sample(), 1'($urandom), 1'b0, none);
         end
      end

      drain();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (2 * PIPE_CYCLES) @(posedge clock);

      $display("Sent %0d sample pairs and checked %0d results across %0d register writes,",
               pairs_sent, results_checked, csr_writes);
      $display("covering depths from zero past the maximum and amounts from zero to full scale.");
      if (error_count == 0 && shaped_q.size() == 0) begin
         $display("iterated_cubic_waveshaper_core test passed");
      end else begin
         $display("%0d mismatches, %0d results never arrived", error_count, shaped_q.size());
         $display("iterated_cubic_waveshaper_core test failed");
      end
      $finish;
   end

endmodule
